// ===== rtl/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the
// frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0]  START_BYTE_RST    = 8'd170;
  localparam logic [23:0] TIMEOUT_TICKS_RST = 24'd1000;

  // register decode on paddr[2]
  localparam logic REG_START_BYTE    = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  // operation field
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_HUNT,
    S_ID,
    S_LEN,
    S_DATA,
    S_CRC_LO,
    S_CRC_HI,
    S_PLAY
  } state_e;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BADLEN  = 2'd1,
    ST_BADCRC  = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    frame_start;
    logic    ld_id;
    logic    ld_len;
    logic    crc_upd;
    logic    wr_data;
    logic    ld_crc_lo;
    logic    clr_idle;
    logic    inc_idle;
    logic    rd_first;
    logic    rd_next;
    logic    out_load;
    status_e out_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic len_bad;
    logic data_done;
    logic crc_ok;
    logic timeout_hit;
    logic play_last;
    logic out_free;
  } sts_t;

  // MSB-first CRC update over one byte
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/crcfr_datapath.sv =====
// ----------------------------------------------------------------------------
// crcfr_datapath
// Frame fields, running CRC, gap counter, payload buffer and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module crcfr_datapath import crcfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  start_byte_i,
  input  logic [23:0] timeout_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  frame_id_o,
  output logic [7:0]  frame_length_o,
  output logic [7:0]  payload_byte_o,
  output logic [5:0]  byte_index_o,
  output logic        last_o
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

  logic [7:0]    held_id_q, held_id_d;
  logic [7:0]    held_len_q, held_len_d;
  logic [AW-1:0] count_q, count_d;
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    crc_lo_q;
  logic [23:0]   idle_q, idle_d, idle_inc;
  logic [AW-1:0] pidx_q, pidx_d;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_q;
  logic [7:0]    mem_q [MAX_PAYLOAD];

  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [7:0]    frame_id_q, frame_length_q, payload_byte_q;
  logic [5:0]    byte_index_q;
  logic          last_q;
  logic          is_good;

  assign idle_inc = (idle_q == 24'hFFFFFF) ? idle_q : idle_q + 24'd1;

  always_comb begin
    sts_o.is_start    = (rx_byte_i == start_byte_i);
    sts_o.len_bad     = (rx_byte_i == 8'd0) || ({1'b0, rx_byte_i} > MAX_LEN);
    sts_o.data_done   = (9'(count_q) + 9'd1) >= {1'b0, held_len_q};
    sts_o.crc_ok      = ({rx_byte_i, crc_lo_q} == crc_q);
    sts_o.timeout_hit = (idle_inc >= timeout_ticks_i);
    sts_o.play_last   = (9'(pidx_q) + 9'd1) == {1'b0, held_len_q};
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    held_id_d  = held_id_q;
    held_len_d = held_len_q;
    count_d    = count_q;
    crc_d      = crc_q;
    idle_d     = idle_q;
    pidx_d     = pidx_q;
    if (cmd_i.frame_start) begin
      held_id_d  = 8'd0;
      held_len_d = 8'd0;
      count_d    = '0;
      crc_d      = crc16_update(CRC_INIT, rx_byte_i);
    end
    if (cmd_i.ld_id) begin
      held_id_d = rx_byte_i;
    end
    if (cmd_i.ld_len) begin
      held_len_d = rx_byte_i;
      count_d    = '0;
    end
    if (cmd_i.crc_upd) begin
      crc_d = crc16_update(crc_q, rx_byte_i);
    end
    if (cmd_i.wr_data) begin
      count_d = count_q + AW'(1);
    end
    if (cmd_i.clr_idle) begin
      idle_d = 24'd0;
    end else if (cmd_i.inc_idle) begin
      idle_d = idle_inc;
    end
    if (cmd_i.rd_first) begin
      pidx_d = '0;
    end else if (cmd_i.rd_next) begin
      pidx_d = pidx_q + AW'(1);
    end
  end

  assign rd_addr = cmd_i.rd_first ? '0 : pidx_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_id_q  <= 8'd0;
      held_len_q <= 8'd0;
      count_q    <= '0;
      crc_q      <= CRC_INIT;
      crc_lo_q   <= 8'd0;
      idle_q     <= 24'd0;
      pidx_q     <= '0;
    end else begin
      held_id_q  <= held_id_d;
      held_len_q <= held_len_d;
      count_q    <= count_d;
      crc_q      <= crc_d;
      idle_q     <= idle_d;
      pidx_q     <= pidx_d;
      if (cmd_i.frame_start) begin
        crc_lo_q <= 8'd0;
      end else if (cmd_i.ld_crc_lo) begin
        crc_lo_q <= rx_byte_i;
      end
    end
  end

  // payload buffer, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_data) begin
      mem_q[count_q] <= rx_byte_i;
    end
    if (cmd_i.rd_first || cmd_i.rd_next) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign is_good = (cmd_i.out_status == ST_GOOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q       <= cmd_i.out_status;
      frame_id_q     <= held_id_q;
      // a bad-length report carries the length byte of this very beat
      frame_length_q <= cmd_i.ld_len ? rx_byte_i : held_len_q;
      payload_byte_q <= is_good ? rd_q : 8'd0;
      byte_index_q   <= is_good ? 6'(pidx_q) : 6'd0;
      last_q         <= is_good ? sts_o.play_last : 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign frame_id_o     = frame_id_q;
  assign frame_length_o = frame_length_q;
  assign payload_byte_o = payload_byte_q;
  assign byte_index_o   = byte_index_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/crcfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// crcfr_ctrl
// Frame state machine: decodes each accepted beat, sequences the payload
// playout and issues datapath commands.
// ----------------------------------------------------------------------------
module crcfr_ctrl import crcfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic operation_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // input waits during playout and while the output register is blocked
  assign in_stall_o = (state_q == S_PLAY) || !sts_i.out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_status = ST_GOOD;
    if (state_q == S_PLAY) begin
      if (sts_i.out_free) begin
        cmd_o.out_load = 1'b1;
        if (sts_i.play_last) begin
          state_d = S_HUNT;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
    end else if (accept) begin
      if (operation_i == OP_TICK) begin
        if (state_q == S_HUNT) begin
          cmd_o.clr_idle = 1'b1;
        end else if (sts_i.timeout_hit) begin
          cmd_o.clr_idle   = 1'b1;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_TIMEOUT;
          state_d          = S_HUNT;
        end else begin
          cmd_o.inc_idle = 1'b1;
        end
      end else begin
        cmd_o.clr_idle = 1'b1;
        case (state_q)
          S_HUNT: begin
            if (sts_i.is_start) begin
              cmd_o.frame_start = 1'b1;
              state_d           = S_ID;
            end
          end
          S_ID: begin
            cmd_o.ld_id   = 1'b1;
            cmd_o.crc_upd = 1'b1;
            state_d       = S_LEN;
          end
          S_LEN: begin
            cmd_o.ld_len = 1'b1;
            if (sts_i.len_bad) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = ST_BADLEN;
              state_d          = S_HUNT;
            end else begin
              cmd_o.crc_upd = 1'b1;
              state_d       = S_DATA;
            end
          end
          S_DATA: begin
            cmd_o.wr_data = 1'b1;
            cmd_o.crc_upd = 1'b1;
            if (sts_i.data_done) begin
              state_d = S_CRC_LO;
            end
          end
          S_CRC_LO: begin
            cmd_o.ld_crc_lo = 1'b1;
            state_d         = S_CRC_HI;
          end
          S_CRC_HI: begin
            if (sts_i.crc_ok) begin
              cmd_o.rd_first = 1'b1;
              state_d        = S_PLAY;
            end else begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = ST_BADCRC;
              state_d          = S_HUNT;
            end
          end
          default: begin
            state_d = S_HUNT;
          end
        endcase
      end
    end
  end

  a_no_load_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded into a blocked output register");

  a_report_then_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_status != ST_GOOD) |=> (state_q == S_HUNT))
    else $error("report not followed by hunting");

  a_good_crc_starts_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_first |=> (state_q == S_PLAY))
    else $error("payload read issued without entering playout");

  a_play_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLAY && cmd_o.out_load && sts_i.play_last) |=> (state_q == S_HUNT))
    else $error("playout did not end after the last payload byte");

endmodule

// ===== rtl/crc16_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_receiver_core
// Start/id/length framed byte receiver with CRC-16/CCITT-FALSE check,
// inter-byte timeout and payload playout; APB-style configuration.
// ----------------------------------------------------------------------------
// Output: a report beat appears in the cycle after the byte or tick that causes
//   it; a good frame's payload is read on the CRC byte, then loaded in playout.
// Throughput: one input beat per cycle while the output is free; a good frame
//   then holds the input while the buffer plays out.
// Reset: async, active low; back to hunting, start_byte 170, timeout 1000;
//   the payload buffer is not cleared.
module crc16_frame_receiver_core import crcfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  frame_id_o,
  output logic [7:0]  frame_length_o,
  output logic [7:0]  payload_byte_o,
  output logic [5:0]  byte_index_o,
  output logic        last_o
);

  logic [7:0]  start_byte_q;
  logic [23:0] timeout_ticks_q;
  logic        cfg_wr;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q    <= START_BYTE_RST;
      timeout_ticks_q <= TIMEOUT_TICKS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_START_BYTE) begin
        start_byte_q <= pwdata[7:0];
      end else begin
        timeout_ticks_q <= pwdata[23:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_TIMEOUT_TICKS) ? {8'd0, timeout_ticks_q}
                                                  : {24'd0, start_byte_q};

  crcfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  crcfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rx_byte_i       (rx_byte_i),
    .start_byte_i    (start_byte_q),
    .timeout_ticks_i (timeout_ticks_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .frame_id_o      (frame_id_o),
    .frame_length_o  (frame_length_o),
    .payload_byte_o  (payload_byte_o),
    .byte_index_o    (byte_index_o),
    .last_o          (last_o)
  );

endmodule
